[rtl/ttf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared types, constants and operand tables for the triangle tangent frame
// block.
// ----------------------------------------------------------------------------
package ttf_pkg;

    // Default parameter values.
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int OUT_FRAC_BITS_DEF = 14;

    // Working widths.
    localparam int MAG_W      = 64;   // magnitude of a working vector lane
    localparam int ACC_W      = 66;   // product accumulator
    localparam int PROD_W     = 64;   // one 32 x 32 signed product
    localparam int OPND_W     = 32;   // multiplier operand
    localparam int SCALE_TOP  = 31;   // block scaling puts the peak in [2^30, 2^31)
    localparam int LANES      = 6;    // lanes of the working vector
    localparam int OUT_W      = 16;   // result component width
    localparam int N_COMP     = 9;    // result components
    localparam int SQRT_STEPS = 32;   // one result bit and two bits of a 64-bit radicand per step
    localparam int CNT_W      = 6;    // step counter for root and divide
    localparam int TERM_W     = 5;    // product term index
    localparam int Q_MAX      = 32767;

    // A-side operand codes.
    localparam logic [2:0] OPA_UV0 = 3'd0;
    localparam logic [2:0] OPA_UV1 = 3'd1;
    localparam logic [2:0] OPA_UV2 = 3'd2;
    localparam logic [2:0] OPA_UV3 = 3'd3;
    localparam logic [2:0] OPA_T0  = 3'd4;
    localparam logic [2:0] OPA_T1  = 3'd5;
    localparam logic [2:0] OPA_T2  = 3'd6;

    // B-side operand codes.
    localparam logic [3:0] OPB_UV1 = 4'd0;
    localparam logic [3:0] OPB_UV3 = 4'd1;
    localparam logic [3:0] OPB_E0  = 4'd2;
    localparam logic [3:0] OPB_E1  = 4'd3;
    localparam logic [3:0] OPB_E2  = 4'd4;
    localparam logic [3:0] OPB_E3  = 4'd5;
    localparam logic [3:0] OPB_E4  = 4'd6;
    localparam logic [3:0] OPB_E5  = 4'd7;
    localparam logic [3:0] OPB_B0  = 4'd8;
    localparam logic [3:0] OPB_B1  = 4'd9;
    localparam logic [3:0] OPB_B2  = 4'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              store_corner;
        logic              corner_slot;
        logic              launch;
        logic              scale;
        logic              store_e;
        logic              load_uv;
        logic              store_uv;
        logic              mul;
        logic              sq_mul;
        logic [TERM_W-1:0] term;
        logic [1:0]        lane;
        logic              acc_load;
        logic              acc_add;
        logic              acc_sub;
        logic              wr_det;
        logic              wr_vec;
        logic              vec_flip;
        logic              store_t;
        logic              store_b;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              div_init;
        logic              div_step;
        logic              q_wr;
        logic [3:0]        q_idx;
        logic              out_load;
        logic              out_deg;
    } ttf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scale_done;
        logic scale_zero;
        logic acc_zero;
    } ttf_status_t;

    // Each pair of terms forms one value as first product minus second product:
    // the determinant, then tangent, binormal and normal components.
    function automatic logic [2:0] term_opa(input logic [TERM_W-1:0] term);
        logic [2:0] r;
        unique case (term)
            5'd0:    r = OPA_UV0;
            5'd1:    r = OPA_UV2;
            5'd2:    r = OPA_UV3;
            5'd3:    r = OPA_UV1;
            5'd4:    r = OPA_UV3;
            5'd5:    r = OPA_UV1;
            5'd6:    r = OPA_UV3;
            5'd7:    r = OPA_UV1;
            5'd8:    r = OPA_UV0;
            5'd9:    r = OPA_UV2;
            5'd10:   r = OPA_UV0;
            5'd11:   r = OPA_UV2;
            5'd12:   r = OPA_UV0;
            5'd13:   r = OPA_UV2;
            5'd14:   r = OPA_T1;
            5'd15:   r = OPA_T2;
            5'd16:   r = OPA_T2;
            5'd17:   r = OPA_T0;
            5'd18:   r = OPA_T0;
            5'd19:   r = OPA_T1;
            default: r = OPA_UV0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] term_opb(input logic [TERM_W-1:0] term);
        logic [3:0] r;
        unique case (term)
            5'd0:    r = OPB_UV3;
            5'd1:    r = OPB_UV1;
            5'd2:    r = OPB_E0;
            5'd3:    r = OPB_E3;
            5'd4:    r = OPB_E1;
            5'd5:    r = OPB_E4;
            5'd6:    r = OPB_E2;
            5'd7:    r = OPB_E5;
            5'd8:    r = OPB_E3;
            5'd9:    r = OPB_E0;
            5'd10:   r = OPB_E4;
            5'd11:   r = OPB_E1;
            5'd12:   r = OPB_E5;
            5'd13:   r = OPB_E2;
            5'd14:   r = OPB_B2;
            5'd15:   r = OPB_B1;
            5'd16:   r = OPB_B0;
            5'd17:   r = OPB_B2;
            5'd18:   r = OPB_B1;
            5'd19:   r = OPB_B0;
            default: r = OPB_UV1;
        endcase
        return r;
    endfunction

endpackage

[rtl/ttf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_dp
// Datapath: corner store, block-scaling shifter, shared multiplier and
// accumulator, bit-pair square root, restoring divider and result register.
// ----------------------------------------------------------------------------
module ttf_dp
    import ttf_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_WIDTH-1:0] in_coord [5],
    input  ttf_cmd_t                      cmd,
    output ttf_status_t                   status,
    output logic signed [OUT_W-1:0]       res_q [N_COMP],
    output logic                          res_deg
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int Q_W   = OUT_FRAC_BITS + 1;
    localparam int NUM_W = 32 + OUT_FRAC_BITS;
    localparam int REM_W = 32;

    // Magnitude of a signed coordinate difference.
    function automatic logic [MAG_W-1:0] delta_mag(input logic signed [DW-1:0] d);
        logic [DW-1:0] m;
        m = d[DW-1] ? DW'(-d) : DW'(d);
        return MAG_W'(m);
    endfunction

    // Signed 32-bit value of a scaled lane (its magnitude is below 2^31).
    function automatic logic signed [OPND_W-1:0] to_s32(input logic s,
                                                        input logic [MAG_W-1:0] m);
        logic signed [OPND_W-1:0] v;
        v = signed'(m[OPND_W-1:0]);
        return s ? -v : v;
    endfunction

    logic signed [COORD_WIDTH-1:0] cor0_reg [5];
    logic signed [COORD_WIDTH-1:0] cor1_reg [5];
    logic signed [DW-1:0]          uvd_reg  [4];
    logic signed [DW-1:0]          dlt      [10];

    logic [MAG_W-1:0] vm_reg [LANES];
    logic [MAG_W-1:0] vm_next [LANES];
    logic             vs_reg [LANES];
    logic             vs_next [LANES];
    logic [2:0]       lane_ix;

    logic signed [OPND_W-1:0] uv_reg [4];
    logic signed [OPND_W-1:0] e_reg  [6];
    logic signed [OPND_W-1:0] t_reg  [3];
    logic signed [OPND_W-1:0] b_reg  [3];

    logic signed [OPND_W-1:0] opa;
    logic signed [OPND_W-1:0] opb;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_abs;
    logic                     det_neg_reg;

    logic [MAG_W-1:0] or_all;
    logic             sc_hi;
    logic             sc_done;
    logic             sc_zero;

    logic [MAG_W-1:0] s_reg;
    logic [MAG_W-1:0] r_reg;
    logic [MAG_W-1:0] bit_reg;
    logic [MAG_W-1:0] rb_sum;

    logic [REM_W-1:0] rem_reg;
    logic [Q_W-1:0]   qr_reg;
    logic [NUM_W-1:0] num;
    logic [REM_W:0]   trial;
    logic             ge;

    logic [31:0]              q32;
    logic [14:0]              qsat;
    logic signed [OUT_W-1:0]  qval;
    logic signed [OUT_W-1:0]  q_reg [N_COMP];

    // The lane command addresses the first four lanes of the six-entry working vector.
    assign lane_ix = {1'b0, cmd.lane};

    // Coordinate differences against the first corner (corner zero).
    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            dlt[j]     = DW'(cor1_reg[j]) - DW'(cor0_reg[j]);
            dlt[5 + j] = DW'(in_coord[j]) - DW'(cor0_reg[j]);
        end
    end

    // Corner store and held UV deltas.
    always_ff @(posedge clk)
    begin
        if (cmd.store_corner && !cmd.corner_slot)
        begin
            for (int j = 0; j < 5; j++) cor0_reg[j] <= in_coord[j];
        end
        if (cmd.store_corner && cmd.corner_slot)
        begin
            for (int j = 0; j < 5; j++) cor1_reg[j] <= in_coord[j];
        end
        if (cmd.launch)
        begin
            uvd_reg[0] <= dlt[3];
            uvd_reg[1] <= dlt[4];
            uvd_reg[2] <= dlt[8];
            uvd_reg[3] <= dlt[9];
        end
    end

    // Block scaling looks only at the OR of the magnitudes: its top bit is the peak's.
    always_comb
    begin
        or_all = '0;
        for (int i = 0; i < LANES; i++) or_all = or_all | vm_reg[i];
        sc_hi   = |or_all[MAG_W-1:SCALE_TOP];
        sc_zero = (or_all == '0);
        sc_done = sc_zero || (!sc_hi && or_all[SCALE_TOP-1]);
    end

    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    // Working vector: loaded, cleared, written a lane at a time, or shifted one bit a cycle.
    always_comb
    begin
        vm_next = vm_reg;
        vs_next = vs_reg;
        priority if (cmd.launch)
        begin
            vm_next[0] = delta_mag(dlt[0]);
            vm_next[1] = delta_mag(dlt[1]);
            vm_next[2] = delta_mag(dlt[2]);
            vm_next[3] = delta_mag(dlt[5]);
            vm_next[4] = delta_mag(dlt[6]);
            vm_next[5] = delta_mag(dlt[7]);
            vs_next[0] = dlt[0][DW-1];
            vs_next[1] = dlt[1][DW-1];
            vs_next[2] = dlt[2][DW-1];
            vs_next[3] = dlt[5][DW-1];
            vs_next[4] = dlt[6][DW-1];
            vs_next[5] = dlt[7][DW-1];
        end
        else if (cmd.load_uv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                vm_next[i] = delta_mag(uvd_reg[i]);
                vs_next[i] = uvd_reg[i][DW-1];
            end
            vm_next[4] = '0;
            vm_next[5] = '0;
            vs_next[4] = 1'b0;
            vs_next[5] = 1'b0;
        end
        else if (cmd.store_uv)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                vm_next[i] = '0;
                vs_next[i] = 1'b0;
            end
        end
        else if (cmd.wr_vec)
        begin
            vm_next[lane_ix] = acc_abs[MAG_W-1:0];
            vs_next[lane_ix] = acc_reg[ACC_W-1] ^ (cmd.vec_flip && det_neg_reg);
        end
        else if (cmd.scale && !sc_done)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                vm_next[i] = sc_hi ? (vm_reg[i] >> 1) : (vm_reg[i] << 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vm_reg <= vm_next;
        vs_reg <= vs_next;
    end

    // Scaled operand banks.
    always_ff @(posedge clk)
    begin
        if (cmd.store_e)
        begin
            for (int i = 0; i < 6; i++) e_reg[i] <= to_s32(vs_reg[i], vm_reg[i]);
        end
        if (cmd.store_uv)
        begin
            for (int i = 0; i < 4; i++) uv_reg[i] <= to_s32(vs_reg[i], vm_reg[i]);
        end
        if (cmd.store_t)
        begin
            for (int i = 0; i < 3; i++) t_reg[i] <= to_s32(vs_reg[i], vm_reg[i]);
        end
        if (cmd.store_b)
        begin
            for (int i = 0; i < 3; i++) b_reg[i] <= to_s32(vs_reg[i], vm_reg[i]);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (term_opa(cmd.term))
            OPA_UV0: opa = uv_reg[0];
            OPA_UV1: opa = uv_reg[1];
            OPA_UV2: opa = uv_reg[2];
            OPA_UV3: opa = uv_reg[3];
            OPA_T0:  opa = t_reg[0];
            OPA_T1:  opa = t_reg[1];
            OPA_T2:  opa = t_reg[2];
            default: opa = uv_reg[0];
        endcase
        unique case (term_opb(cmd.term))
            OPB_UV1: opb = uv_reg[1];
            OPB_UV3: opb = uv_reg[3];
            OPB_E0:  opb = e_reg[0];
            OPB_E1:  opb = e_reg[1];
            OPB_E2:  opb = e_reg[2];
            OPB_E3:  opb = e_reg[3];
            OPB_E4:  opb = e_reg[4];
            OPB_E5:  opb = e_reg[5];
            OPB_B0:  opb = b_reg[0];
            OPB_B1:  opb = b_reg[1];
            OPB_B2:  opb = b_reg[2];
            default: opb = uv_reg[1];
        endcase
        if (cmd.sq_mul)
        begin
            opa = signed'({1'b0, vm_reg[lane_ix][OPND_W-2:0]});
            opb = opa;
        end
    end

    assign prod_ext = ACC_W'(prod_reg);

    // Multiplier, accumulator and determinant sign.
    always_ff @(posedge clk)
    begin
        if (cmd.mul || cmd.sq_mul)
        begin
            prod_reg <= opa * opb;
        end
        priority if (cmd.acc_load) acc_reg <= prod_ext;
        else if (cmd.acc_add)      acc_reg <= acc_reg + prod_ext;
        else if (cmd.acc_sub)      acc_reg <= acc_reg - prod_ext;
        if (cmd.wr_det)
        begin
            det_neg_reg <= acc_reg[ACC_W-1];
        end
    end

    // Integer square root, two radicand bits a step.
    assign rb_sum = r_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            s_reg   <= acc_reg[MAG_W-1:0];
            r_reg   <= '0;
            bit_reg <= MAG_W'(1) << (MAG_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (s_reg >= rb_sum)
            begin
                s_reg <= s_reg - rb_sum;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Restoring divider; the quotient never exceeds OUT_FRAC_BITS + 1 bits.
    assign num   = (NUM_W'(vm_reg[lane_ix][OPND_W-2:0]) << OUT_FRAC_BITS)
                 + NUM_W'(r_reg[31:1]);
    assign trial = {rem_reg, qr_reg[Q_W-1]};
    assign ge    = (trial >= {1'b0, r_reg[31:0]});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= REM_W'(num[NUM_W-1:Q_W]);
            qr_reg  <= num[Q_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? REM_W'(trial - {1'b0, r_reg[31:0]}) : trial[REM_W-1:0];
            qr_reg  <= {qr_reg[Q_W-2:0], ge};
        end
    end

    // Saturate and sign the quotient.
    always_comb
    begin
        q32  = 32'(qr_reg);
        qsat = (q32 > 32'(Q_MAX)) ? 15'(Q_MAX) : q32[14:0];
        qval = vs_reg[lane_ix] ? -signed'({1'b0, qsat}) : signed'({1'b0, qsat});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_wr)
        begin
            q_reg[cmd.q_idx] <= qval;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_deg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_deg <= cmd.out_deg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int i = 0; i < N_COMP; i++) res_q[i] <= cmd.out_deg ? '0 : q_reg[i];
        end
    end

    assign status.scale_done = sc_done;
    assign status.scale_zero = sc_zero;
    assign status.acc_zero   = (acc_reg == '0);

endmodule

[rtl/ttf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_ctrl
// Controller: corner grouping, the sequence of the frame calculation and
// the output handshake.
// ----------------------------------------------------------------------------
module ttf_ctrl
    import ttf_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        first_of_mesh,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  ttf_status_t status,
    output ttf_cmd_t    cmd
);

    localparam int Q_W = OUT_FRAC_BITS + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCE  = 4'd1;
    localparam logic [3:0] S_SCUV = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_WR   = 4'd5;
    localparam logic [3:0] S_SCV  = 4'd6;
    localparam logic [3:0] S_SQM  = 4'd7;
    localparam logic [3:0] S_SQA  = 4'd8;
    localparam logic [3:0] S_SQI  = 4'd9;
    localparam logic [3:0] S_SQRT = 4'd10;
    localparam logic [3:0] S_DVI  = 4'd11;
    localparam logic [3:0] S_DIV  = 4'd12;
    localparam logic [3:0] S_DVW  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    localparam logic [1:0] V_T = 2'd0;
    localparam logic [1:0] V_B = 2'd1;
    localparam logic [1:0] V_N = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        count_reg, count_next;
    logic [TERM_W-1:0] term_reg,  term_next;
    logic [1:0]        lane_reg,  lane_next;
    logic [1:0]        vsel_reg,  vsel_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic              deg_reg,   deg_next;
    logic              ov_reg,    ov_next;
    logic [1:0]        eff_count;

    assign eff_count = first_of_mesh ? 2'd0 : count_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        term_next  = term_reg;
        lane_next  = lane_reg;
        vsel_next  = vsel_reg;
        cnt_next   = cnt_reg;
        deg_next   = deg_reg;
        ov_next    = (ov_reg && out_ready) ? 1'b0 : ov_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        cmd.lane   = lane_reg;
        cmd.q_idx  = 4'(vsel_reg) * 4'd3 + 4'(lane_reg);
        cmd.out_deg = deg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (eff_count != 2'd2)
                    begin
                        cmd.store_corner = 1'b1;
                        cmd.corner_slot  = eff_count[0];
                        count_next       = eff_count + 2'd1;
                    end
                    else
                    begin
                        cmd.launch = 1'b1;
                        count_next = 2'd0;
                        deg_next   = 1'b0;
                        state_next = S_SCE;
                    end
                end
            end
            S_SCE:
            begin
                cmd.scale = 1'b1;
                if (status.scale_done)
                begin
                    cmd.store_e = 1'b1;
                    cmd.load_uv = 1'b1;
                    state_next  = S_SCUV;
                end
            end
            S_SCUV:
            begin
                cmd.scale = 1'b1;
                if (status.scale_done)
                begin
                    cmd.store_uv = 1'b1;
                    term_next    = '0;
                    lane_next    = 2'd0;
                    vsel_next    = V_T;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!term_reg[0])
                begin
                    cmd.acc_load = 1'b1;
                    term_next    = term_reg + TERM_W'(1);
                    state_next   = S_MUL;
                end
                else
                begin
                    cmd.acc_sub = 1'b1;
                    state_next  = S_WR;
                end
            end
            S_WR:
            begin
                term_next = term_reg + TERM_W'(1);
                if (term_reg == TERM_W'(1))
                begin
                    // Determinant: zero ends the triangle as degenerate.
                    cmd.wr_det = 1'b1;
                    if (status.acc_zero)
                    begin
                        deg_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    cmd.wr_vec   = 1'b1;
                    cmd.vec_flip = (vsel_reg != V_N);
                    if (lane_reg == 2'd2)
                    begin
                        lane_next  = 2'd0;
                        state_next = S_SCV;
                    end
                    else
                    begin
                        lane_next  = lane_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_SCV:
            begin
                cmd.scale = 1'b1;
                if (status.scale_done)
                begin
                    if (status.scale_zero)
                    begin
                        deg_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.store_t = (vsel_reg == V_T);
                        cmd.store_b = (vsel_reg == V_B);
                        lane_next   = 2'd0;
                        state_next  = S_SQM;
                    end
                end
            end
            S_SQM:
            begin
                cmd.sq_mul = 1'b1;
                state_next = S_SQA;
            end
            S_SQA:
            begin
                if (lane_reg == 2'd0)
                begin
                    cmd.acc_load = 1'b1;
                end
                else
                begin
                    cmd.acc_add = 1'b1;
                end
                if (lane_reg == 2'd2)
                begin
                    lane_next  = 2'd0;
                    state_next = S_SQI;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_SQM;
                end
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_DVI;
                end
            end
            S_DVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = S_DVW;
                end
            end
            S_DVW:
            begin
                cmd.q_wr = 1'b1;
                if (lane_reg == 2'd2)
                begin
                    lane_next = 2'd0;
                    if (vsel_reg == V_N)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        vsel_next  = vsel_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_DVI;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= 2'd0;
            term_reg  <= '0;
            lane_reg  <= 2'd0;
            vsel_reg  <= V_T;
            cnt_reg   <= '0;
            deg_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            term_reg  <= term_next;
            lane_reg  <= lane_next;
            vsel_reg  <= vsel_next;
            cnt_reg   <= cnt_next;
            deg_reg   <= deg_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

[rtl/triangle_tangent_frame_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_frame_core
// Per-triangle unit tangent, binormal and normal from a triangle-list stream.
// ----------------------------------------------------------------------------
// The first two corners of a triangle are each stored as they are taken. The third
// corner starts the frame calculation, during which no corner is taken; it
// runs on one shared 32 x 32 multiplier, a block-scaling shifter that moves
// the working vector one bit a cycle, a 32-step square root and an
// (OUT_FRAC_BITS + 1)-step restoring divider. The shifter makes up the part
// of the calculation time that depends on the data. A degenerate triangle
// finishes early. A finished word waits in the output register while the
// next triangle's first two corners are taken.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_core
    import ttf_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          first_of_mesh,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic signed [COORD_WIDTH-1:0] tex_u,
    input  logic signed [COORD_WIDTH-1:0] tex_v,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_W-1:0]       tangent_x,
    output logic signed [OUT_W-1:0]       tangent_y,
    output logic signed [OUT_W-1:0]       tangent_z,
    output logic signed [OUT_W-1:0]       binormal_x,
    output logic signed [OUT_W-1:0]       binormal_y,
    output logic signed [OUT_W-1:0]       binormal_z,
    output logic signed [OUT_W-1:0]       normal_x,
    output logic signed [OUT_W-1:0]       normal_y,
    output logic signed [OUT_W-1:0]       normal_z,
    output logic                          degenerate
);

    ttf_cmd_t                      cmd;
    ttf_status_t                   status;
    logic signed [COORD_WIDTH-1:0] in_coord [5];
    logic signed [OUT_W-1:0]       res_q [N_COMP];

    assign in_coord[0] = pos_x;
    assign in_coord[1] = pos_y;
    assign in_coord[2] = pos_z;
    assign in_coord[3] = tex_u;
    assign in_coord[4] = tex_v;

    ttf_ctrl #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .first_of_mesh (first_of_mesh),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .cmd           (cmd)
    );

    ttf_dp #(
        .COORD_WIDTH   (COORD_WIDTH),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_coord (in_coord),
        .cmd      (cmd),
        .status   (status),
        .res_q    (res_q),
        .res_deg  (degenerate)
    );

    assign tangent_x  = res_q[0];
    assign tangent_y  = res_q[1];
    assign tangent_z  = res_q[2];
    assign binormal_x = res_q[3];
    assign binormal_y = res_q[4];
    assign binormal_z = res_q[5];
    assign normal_x   = res_q[6];
    assign normal_y   = res_q[7];
    assign normal_z   = res_q[8];

    // A degenerate word carries all-zero vectors.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            tangent_x == 0 && tangent_y == 0 && tangent_z == 0 &&
            binormal_x == 0 && binormal_y == 0 && binormal_z == 0 &&
            normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("degenerate word with non-zero vector");

    // Saturation keeps every component off the most negative code.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            tangent_x != -32768 && tangent_y != -32768 && tangent_z != -32768 &&
            binormal_x != -32768 && binormal_y != -32768 &&
            binormal_z != -32768 && normal_x != -32768 &&
            normal_y != -32768 && normal_z != -32768)
        else $error("component outside the saturated range");

    // A result never appears in the cycle after a corner is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result raised straight after a corner");

    // Corners are not taken while the output word is being loaded.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !in_ready)
        else $error("corner taken during result load");

endmodule
